/* rtl/ssr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_pkg: shared types and constants
// Register indexes, state codes and datapath command/status structs.
// ---------------------------------------------------------------------------
package ssr_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_RATE   = 2'd0,
    REG_TARGET_WIDTH  = 2'd1,
    REG_TARGET_HEIGHT = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;   // latch sample, update current sums and position
    logic rd_line;  // issue line memory read
    logic fold;     // fold current sum with line entry, write back
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pixel_last;  // this sample closes a pixel in its sample row
    logic emit;        // closing sample row of the pixel
    logic div_done;
  } sts_t;

endpackage

/* rtl/ssr_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_if: valid/ready channel
// Generic handshake channel carrying a packed payload.
// ---------------------------------------------------------------------------
interface ssr_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ssr_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_ctrl: resolve sequencer
// Accepts samples, runs read and fold per pixel row, divide and output per pixel.
// ---------------------------------------------------------------------------
module ssr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ssr_pkg::sts_t sts_i,
  output ssr_pkg::cmd_t cmd_o
);
  import ssr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.pixel_last) begin
            cmd_o.rd_line = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_SUM;
      ST_SUM: begin
        cmd_o.fold = 1'b1;
        if (sts_i.emit) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // hold until the output register has drained
        if (sts_i.div_done && !(out_valid_i && !out_ready_i)) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* rtl/ssr_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_dp: resolve datapath
// Position counters, line accumulator memory, serial divider, output reg.
// ---------------------------------------------------------------------------
module ssr_dp #(
  parameter int unsigned MaxRate  = 4,
  parameter int unsigned MaxWidth = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ssr_pkg::cmd_t                    cmd_i,
  output ssr_pkg::sts_t                    sts_o,
  input  logic                             cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ssr_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [31:0]                      sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [52:0]                      pixel_o
);
  import ssr_pkg::*;

  localparam int unsigned RW = $clog2(MaxRate + 1);
  localparam int unsigned SW = $clog2(MaxRate);
  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned WW = $clog2(MaxWidth + 1);
  localparam int unsigned SumW = $clog2(255 * MaxRate * MaxRate + 1);
  localparam int unsigned NumW = SumW + 8;
  localparam int unsigned DCntW = $clog2(NumW + 1);

  // configuration
  logic [2:0]  rate_reg_q;
  logic [10:0] width_reg_q, height_reg_q;
  logic        restart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_reg_q   <= 3'd1;
      width_reg_q  <= 11'd640;
      height_reg_q <= 11'd480;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SAMPLE_RATE:   rate_reg_q   <= cfg_data_i[2:0];
        REG_TARGET_WIDTH:  width_reg_q  <= cfg_data_i;
        REG_TARGET_HEIGHT: height_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign restart = cfg_we_i && (reg_idx_e'(cfg_idx_i) != REG_UNUSED);

  logic [RW-1:0] rate;
  logic [WW-1:0] width;
  logic [10:0]   height;
  always_comb begin
    if (rate_reg_q == 3'd0) rate = RW'(1);
    else if (32'(rate_reg_q) > MaxRate) rate = RW'(MaxRate);
    else rate = RW'(rate_reg_q);
    if (width_reg_q == 11'd0) width = WW'(1);
    else if (32'(width_reg_q) > MaxWidth) width = WW'(MaxWidth);
    else width = WW'(width_reg_q);
    if (height_reg_q == 11'd0) height = 11'd1;
    else if (height_reg_q > 11'd1024) height = 11'd1024;
    else height = height_reg_q;
  end

  // position and current sums
  logic [SW:0]   subc_q;
  logic [SW:0]   subr_q;
  logic [CW-1:0] col_q;
  logic [10:0]   row_q;
  logic [SumW-1:0] cur_q [4];
  logic [SumW-1:0] fold_q [4];  // sums handed to the fold step
  logic [CW-1:0] fcol_q;
  logic [10:0]   frow_q;
  logic          ffirst_q, femit_q, fend_q;
  logic [SW:0]   subc_inc;

  assign subc_inc = subc_q + 1'b1;
  assign sts_o.pixel_last = ({1'b0, subc_inc} >= (SW + 2)'(rate));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subc_q <= '0;
      subr_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      for (int c = 0; c < 4; c++) cur_q[c] <= '0;
    end else if (restart) begin
      subc_q <= '0;
      subr_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
      for (int c = 0; c < 4; c++) cur_q[c] <= '0;
    end else if (cmd_i.accept) begin
      if (sts_o.pixel_last) begin
        subc_q <= '0;
        for (int c = 0; c < 4; c++) cur_q[c] <= '0;
        if ((WW'(col_q) + 1'b1) >= width) begin
          col_q <= '0;
          if ((RW + 1)'(subr_q) + 1'b1 >= (RW + 1)'(rate)) begin
            subr_q <= '0;
            row_q <= (row_q + 1'b1 >= height) ? 11'd0 : row_q + 1'b1;
          end else begin
            subr_q <= subr_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end else begin
        subc_q <= subc_inc;
        for (int c = 0; c < 4; c++) cur_q[c] <= cur_q[c] + SumW'(sample_i[8*c +: 8]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sts_o.pixel_last) begin
      for (int c = 0; c < 4; c++) fold_q[c] <= cur_q[c] + SumW'(sample_i[8*c +: 8]);
      fcol_q   <= col_q;
      frow_q   <= row_q;
      ffirst_q <= (subr_q == '0);
      femit_q  <= ((RW + 1)'(subr_q) + 1'b1 >= (RW + 1)'(rate));
      fend_q   <= (WW'(col_q) + 1'b1 >= width) && (row_q + 1'b1 >= height);
    end
  end
  assign sts_o.emit = femit_q;

  // line accumulator memory
  logic [4*SumW-1:0] line_mem [MaxWidth];
  logic [4*SumW-1:0] rd_q;
  logic [SumW-1:0]   tot [4];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_line) rd_q <= line_mem[col_q];
    if (cmd_i.fold) line_mem[fcol_q] <= {tot[3], tot[2], tot[1], tot[0]};
  end
  always_comb begin
    for (int c = 0; c < 4; c++)
      tot[c] = ffirst_q ? fold_q[c] : fold_q[c] + rd_q[SumW*c +: SumW];
  end

  // serial divider: three colour quotients and alpha over n, one bit a cycle
  logic [NumW-1:0] rem_q [4];
  logic [NumW-1:0] quo_q [4];
  logic [NumW-1:0] den_q [4];
  logic [DCntW-1:0] dcnt_q;
  logic            busy_q;
  logic [NumW:0]   trial [4];
  logic [NumW-1:0] nsq;

  assign nsq = NumW'(rate) * NumW'(rate);
  always_comb begin
    for (int c = 0; c < 4; c++)
      trial[c] = {rem_q[c], quo_q[c][NumW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      dcnt_q <= DCntW'(NumW);
    end else if (busy_q) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (dcnt_q == DCntW'(1)) busy_q <= 1'b0;
    end
  end
  assign sts_o.div_done = !busy_q && (dcnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      for (int c = 0; c < 4; c++) begin
        rem_q[c]  <= '0;
      end
      for (int c = 0; c < 3; c++) begin
        if (tot[3] != '0) begin
          quo_q[c] <= NumW'(tot[c]) * NumW'(255);
          den_q[c] <= NumW'(tot[3]);
        end else begin
          quo_q[c] <= NumW'(tot[c]);
          den_q[c] <= nsq;
        end
      end
      quo_q[3] <= NumW'(tot[3]);
      den_q[3] <= nsq;
    end else if (busy_q) begin
      for (int c = 0; c < 4; c++) begin
        if (trial[c] >= {1'b0, den_q[c]}) begin
          rem_q[c] <= NumW'(trial[c] - {1'b0, den_q[c]});
          quo_q[c] <= {quo_q[c][NumW-2:0], 1'b1};
        end else begin
          rem_q[c] <= NumW'(trial[c]);
          quo_q[c] <= {quo_q[c][NumW-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic [7:0] res [4];
  always_comb begin
    for (int c = 0; c < 4; c++)
      res[c] = (quo_q[c] > NumW'(255)) ? 8'hFF : quo_q[c][7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load)
      pixel_o <= {fend_q, frow_q[9:0], 10'(fcol_q), res[3], res[2], res[1], res[0]};
  end
endmodule

/* rtl/supersample_resolve_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// supersample_resolve_top: box-filter resolve of a supersampled frame
// Channel      | dir | payload
// sample_if    | in  | {alpha, blue, green, red} bytes
// pixel_if     | out | {frame_end, row, column, alpha, blue, green, red}
// cfg_if       | in  | {index[1:0], data[10:0]}
// A sample inside a pixel is accepted straight from the idle state. A sample
// that closes a pixel in its sample row then passes the line memory read and
// fold states; on the last sample row the serial divider runs as well. Reset
// restores the register defaults; the line memory needs no clearing. A stalled
// output holds the divider result until the pixel register drains.
// ---------------------------------------------------------------------------
module supersample_resolve_top #(
  parameter int unsigned MAX_RATE  = 4,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input logic clk_i,
  input logic rst_ni,
  ssr_if.sink   sample_if,
  ssr_if.source pixel_if,
  ssr_if.sink   cfg_if
);
  import ssr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [52:0] pixel;

  assign cfg_if.ready = 1'b1;

  ssr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_if.valid),
    .in_ready_o  (sample_if.ready),
    .out_valid_i (pixel_if.valid),
    .out_ready_i (pixel_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssr_dp #(.MaxRate(MAX_RATE), .MaxWidth(MAX_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_if.valid),
    .cfg_idx_i   (cfg_if.data[12:11]),
    .cfg_data_i  (cfg_if.data[10:0]),
    .sample_i    (sample_if.data),
    .out_valid_o (pixel_if.valid),
    .out_ready_i (pixel_if.ready),
    .pixel_o     (pixel)
  );
  assign pixel_if.data = pixel;

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(pixel_if.valid && !pixel_if.ready))
    else $error("pixel overwritten while stalled");
  a_fold_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_line |=> ##1 cmd.fold)
    else $error("line fold missing");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fold |-> !sample_if.ready)
    else $error("sample taken during fold");
endmodule

/* bench/supersample_resolve_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// supersample_resolve_checker: pixel predictor and scoreboard
// Watches the sample, pixel and register channels. Every accepted sample
// updates a local model of the resolve, and every pixel it closes is queued.
// Each pixel leaving the block is compared field by field with the oldest
// queued pixel.
// ---------------------------------------------------------------------------
module supersample_resolve_checker
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_RATE  = 4,
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned MAX_ROWS  = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssr_if       sample_mon,
  ssr_if       pixel_mon,
  ssr_if       cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic       frame_end;
    logic [9:0] row;
    logic [9:0] column;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  logic [2:0]  rate_q;
  logic [10:0] width_q;
  logic [10:0] height_q;

  int unsigned col_sums[MAX_WIDTH][4];
  int unsigned run_sum[4];
  int unsigned sub_col, col_pos, sub_row, row_pos;

  pixel_t expected_pixels[$];
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_pixels.size();

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame();
    run_sum = '{default: 0};
    sub_col = 0;
    col_pos = 0;
    sub_row = 0;
    row_pos = 0;
  endtask

  task automatic report(string field, int unsigned got, int unsigned exp);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, exp);
    fails++;
  endtask

  task automatic resolve_sample(logic [31:0] smp);
    int unsigned rate, width, height, col, n, sa, s, v;
    pixel_t      px;
    rate   = clamp_to(rate_q, MAX_RATE);
    width  = clamp_to(width_q, MAX_WIDTH);
    height = clamp_to(height_q, MAX_ROWS);
    col    = col_pos % width;
    for (int c = 0; c < 4; c++) run_sum[c] += smp[8*c +: 8];
    sub_col++;
    if (sub_col < rate) return;
    // fold this sample row's share of the pixel into the column entry
    for (int c = 0; c < 4; c++) begin
      if (sub_row == 0) col_sums[col][c] = run_sum[c];
      else col_sums[col][c] += run_sum[c];
      run_sum[c] = 0;
    end
    sub_col = 0;
    if (sub_row + 1 >= rate) begin
      n  = rate * rate;
      sa = col_sums[col][3];
      for (int c = 0; c < 3; c++) begin
        s = col_sums[col][c];
        if (sa != 0) begin
          v = (s * 255) / sa;
          if (v > 255) v = 255;
        end else begin
          v = s / n;
        end
        case (c)
          0: px.red = v[7:0];
          1: px.green = v[7:0];
          default: px.blue = v[7:0];
        endcase
      end
      px.alpha     = 8'(sa / n);
      px.column    = 10'(col);
      px.row       = 10'(row_pos);
      px.frame_end = (col + 1 >= width) && (row_pos + 1 >= height);
      expected_pixels.push_back(px);
    end
    col++;
    if (col >= width) begin
      col = 0;
      sub_row++;
      if (sub_row >= rate) begin
        sub_row = 0;
        row_pos++;
        if (row_pos >= height) row_pos = 0;
      end
    end
    col_pos = col;
  endtask

  task automatic write_reg(logic [12:0] word);
    reg_idx_e idx;
    idx = reg_idx_e'(word[12:11]);
    case (idx)
      REG_SAMPLE_RATE:   rate_q = word[2:0];
      REG_TARGET_WIDTH:  width_q = word[10:0];
      REG_TARGET_HEIGHT: height_q = word[10:0];
      default: return;
    endcase
    restart_frame();
  endtask

  task automatic check_pixel(pixel_t got);
    pixel_t exp;
    if (expected_pixels.size() == 0) begin
      report("unexpected pixel column", got.column, 0);
      return;
    end
    exp = expected_pixels.pop_front();
    if (got.red != exp.red) report("red", got.red, exp.red);
    if (got.green != exp.green) report("green", got.green, exp.green);
    if (got.blue != exp.blue) report("blue", got.blue, exp.blue);
    if (got.alpha != exp.alpha) report("alpha", got.alpha, exp.alpha);
    if (got.column != exp.column) report("column", got.column, exp.column);
    if (got.row != exp.row) report("row", got.row, exp.row);
    if (got.frame_end != exp.frame_end) report("frame_end", got.frame_end, exp.frame_end);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   = 3'd1;
      width_q  = 11'd640;
      height_q = 11'd480;
      fails    = 0;
      expected_pixels.delete();
      restart_frame();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_reg(cfg_mon.data[12:0]);
      if (pixel_mon.valid && pixel_mon.ready) check_pixel(pixel_t'(pixel_mon.data[52:0]));
      if (sample_mon.valid && sample_mon.ready) resolve_sample(sample_mon.data[31:0]);
    end
  end

endmodule

/* bench/supersample_resolve_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// supersample_resolve_top_tb: testbench top for the supersample resolve
// Drives directed and random supersampled frames over several register
// settings, with random idle bursts on both channels and one long output
// stall, and reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
module supersample_resolve_top_tb;
  import ssr_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 700;
  localparam int unsigned QuietAfter = 600;
  localparam int unsigned SettleCycles = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssr_if #(.W(32)) sample_ch ();
  ssr_if #(.W(53)) pixel_ch ();
  ssr_if #(.W(13)) cfg_ch ();

  int fail_count, pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  int unsigned stall_cnt;

  supersample_resolve_top u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_if (sample_ch),
    .pixel_if  (pixel_ch),
    .cfg_if    (cfg_ch)
  );

  supersample_resolve_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_ch),
    .pixel_mon    (pixel_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // pixel receiver: random stall bursts, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else if (hold_req) begin
      pixel_ch.ready <= 1'b0;
      stall_cnt <= 400;
    end else if (stall_cnt != 0) begin
      pixel_ch.ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      pixel_ch.ready <= 1'b0;
      stall_cnt <= $urandom_range(0, 5);
    end else begin
      pixel_ch.ready <= 1'b1;
    end
  end

  task automatic send_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= {a, b, g, r};
    do @(posedge clk_i); while (!sample_ch.ready);
    sent++;
    if (sent >= QuietAfter) quiet = 1'b1;
  endtask

  // let the block drain before touching a register
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [10:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, value};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(logic [10:0] rate, logic [10:0] width, logic [10:0] height);
    settle();
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_TARGET_WIDTH, width);
    write_reg(REG_TARGET_HEIGHT, height);
  endtask

  task automatic send_random(int unsigned count, int unsigned alpha_mode);
    logic [7:0] a;
    for (int unsigned i = 0; i < count; i++) begin
      case (alpha_mode)
        0: a = 8'd0;
        1: a = 8'($urandom_range(1, 8));
        default: a = 8'($urandom);
      endcase
      send_sample(8'($urandom), 8'($urandom), 8'($urandom), a);
    end
  endtask

  initial begin
    int unsigned rate, width, height, frame_len, phase;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: one sample per pixel
    send_sample(8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(8'd0, 8'd0, 8'd0, 8'd0);
    send_sample(8'd200, 8'd100, 8'd50, 8'd0);
    send_sample(8'd255, 8'd128, 8'd7, 8'd1);
    send_sample(8'h55, 8'hAA, 8'h0F, 8'hF0);

    // zero rate and sizes act as one
    set_frame(11'd0, 11'd0, 11'd0);
    send_sample(8'd10, 8'd20, 8'd30, 8'd40);
    send_sample(8'd255, 8'd0, 8'd255, 8'd3);

    // unused index leaves the frame position alone
    settle();
    write_reg(REG_UNUSED, 11'h7FF);
    send_sample(8'd1, 8'd2, 8'd3, 8'd4);

    // oversized settings saturate
    set_frame(11'd7, 11'h7FF, 11'h7FF);
    send_random(5, 2);
    set_frame(11'd1, 11'd1024, 11'd1024);
    send_random(3, 2);

    // two-by-two pixels, two wide, one high
    set_frame(11'd2, 11'd2, 11'd1);
    send_sample(8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(8'd0, 8'd0, 8'd0, 8'd0);
    send_sample(8'd9, 8'd9, 8'd9, 8'd0);
    send_sample(8'd9, 8'd9, 8'd9, 8'd0);
    send_sample(8'd255, 8'd255, 8'd255, 8'd255);
    send_sample(8'd255, 8'd1, 8'd0, 8'd0);
    send_sample(8'd3, 8'd3, 8'd3, 8'd0);
    send_sample(8'd200, 8'd200, 8'd200, 8'd1);

    phase = 0;
    while (sent < ItemTarget) begin
      rate   = $urandom_range(1, 4);
      width  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      height = $urandom_range(1, 3);
      // keep a frame short so the item count stays near the target
      if (rate * rate * width * height > 64) width = 64 / (rate * rate * height);
      set_frame(11'(rate), 11'(width), 11'(height));
      frame_len = rate * rate * width * height;
      if (phase == 1) begin
        // long output stall while samples keep coming
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      repeat ($urandom_range(1, 2)) begin
        if (phase == 3) begin
          send_random(frame_len / 2, $urandom_range(0, 3));
          sample_ch.valid <= 1'b0;
          @(posedge clk_i);
          wait (pending == 0);
          send_random(frame_len - frame_len / 2, $urandom_range(0, 3));
        end else begin
          send_random(frame_len, $urandom_range(0, 3));
        end
      end
      // broken tail: up to one pixel row of samples before the restart
      if ($urandom_range(0, 3) == 0) send_random($urandom_range(1, rate * rate * width), 2);
      phase++;
    end

    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ssr_pkg.sv
rtl/ssr_if.sv
rtl/ssr_ctrl.sv
rtl/ssr_dp.sv
rtl/supersample_resolve_top.sv
bench/supersample_resolve_checker.sv
bench/supersample_resolve_top_tb.sv
